>>> rtl/av_packet_deframer_assert.svh
// assertion macros for the packet deframer
`ifndef AV_PACKET_DEFRAMER_ASSERT_SVH
`define AV_PACKET_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

`define AVPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed: same-cycle implication");

`define AVPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed: next-cycle implication");

`else

`define AVPD_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define AVPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/avpd_pkg.sv
// shared types and constants for the packet deframer
package avpd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PT_W        = 7;
    localparam int unsigned KIND_W      = 4;
    localparam int unsigned POS_W       = 5;
    localparam int unsigned LEN_W       = 16;
    localparam int unsigned SEQ_OUT_W   = 32;
    localparam int unsigned MAGIC_LEN   = 4;
    localparam int unsigned M_TDATA_W   = 56;
    localparam int unsigned M_TUSER_W   = 8;

    localparam logic [BYTE_W-1:0] MAGIC [MAGIC_LEN] = '{8'h30, 8'h31, 8'h63, 8'h64};

    localparam logic [POS_W-1:0] POS_MAGIC_END = 5'd4;
    localparam logic [POS_W-1:0] POS_PT        = 5'd5;
    localparam logic [POS_W-1:0] POS_KIND      = 5'd15;
    localparam logic [POS_W-1:0] LOFF_SHORT    = 5'd16;
    localparam logic [POS_W-1:0] LOFF_AUDIO    = 5'd24;
    localparam logic [POS_W-1:0] LOFF_DEFAULT  = 5'd28;

    localparam logic [KIND_W-1:0] KIND_VIDEO_MAX = 4'h2;
    localparam logic [KIND_W-1:0] KIND_AUDIO     = 4'h3;
    localparam logic [KIND_W-1:0] KIND_SHORT     = 4'h4;

    localparam logic CH_VIDEO = 1'b0;
    localparam logic CH_AUDIO = 1'b1;

    typedef struct packed {
        logic                 magic_error;
        logic [SEQ_OUT_W-1:0] packet_seq;
        logic [PT_W-1:0]      codec_pt;
        logic [PT_W-1:0]      payload_kind;
        logic                 last_of_packet;
        logic                 first_of_packet;
        logic                 channel;
        logic [BYTE_W-1:0]    payload_byte;
    } t_result;

    function automatic logic [POS_W-1:0] len_offset(input logic [KIND_W-1:0] kind);
        logic [POS_W-1:0] off;
        unique case (kind)
            KIND_SHORT: off = LOFF_SHORT;
            KIND_AUDIO: off = LOFF_AUDIO;
            default:    off = LOFF_DEFAULT;
        endcase
        return off;
    endfunction

endpackage

>>> rtl/av_packet_deframer.sv
// top level of the byte-stream packet deframer with input and result registers
// a byte's result passes the input register and then the result register to m_axis
// throughput: one byte per cycle unless m_axis stalls, limited by the single-byte parser state update
// backpressure stalls the input register only while the result register is held
// reset is synchronous and active low and clears all parser and handshake state
// a magic mismatch emits one error result, then bytes are swallowed until reset
module av_packet_deframer
    import avpd_pkg::*;
#(
    parameter int unsigned SEQ_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BYTE_W-1:0]    s_axis_tdata,   // data_byte
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // payload_byte, first_of_packet,
                                                 // codec_pt, packet_seq, magic_error
    output logic [M_TUSER_W-1:0] m_axis_tuser,   // channel, payload_kind
    output logic                 m_axis_tlast    // last_of_packet
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;

    logic              advance;
    logic              res_valid;
    t_result           res;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    avpd_parser #(
        .SEQ_BITS(SEQ_BITS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_in_valid && advance),
        .i_byte     (r_in_byte),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (advance) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.last_of_packet;
    assign m_axis_tuser  = {r_out.payload_kind, r_out.channel};
    assign m_axis_tdata  = M_TDATA_W'({r_out.magic_error, r_out.packet_seq, r_out.codec_pt,
                                       r_out.first_of_packet, r_out.payload_byte});

endmodule

>>> rtl/avpd_parser.sv
// header parser, body sequencing and result forming for the packet deframer
`include "av_packet_deframer_assert.svh"

module avpd_parser
    import avpd_pkg::*;
#(
    parameter int unsigned SEQ_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_res_valid,
    output t_result           o_res
);

    localparam int unsigned SeqPadW = (SEQ_BITS >= SEQ_OUT_W) ? SEQ_BITS : SEQ_OUT_W;

    logic [POS_W-1:0]    r_hdr_pos, n_hdr_pos;
    logic                r_in_body, n_in_body;
    logic [LEN_W-1:0]    r_remaining, n_remaining;
    logic [BYTE_W-1:0]   r_len_high, n_len_high;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [PT_W-1:0]     r_pt, n_pt;
    logic [PT_W-1:0]     r_codec, n_codec;
    logic                r_codec_seen, n_codec_seen;
    logic [SEQ_BITS-1:0] r_count, n_count;
    logic                r_halted, n_halted;
    logic                r_first, n_first;

    logic [POS_W-1:0]    loff;
    logic [LEN_W-1:0]    hdr_len;
    logic                is_video;
    logic                is_audio;
    logic [SeqPadW-1:0]  seq_pad;

    assign loff     = len_offset(r_kind);
    assign hdr_len  = {r_len_high, i_byte};
    assign is_video = (r_kind <= KIND_VIDEO_MAX);
    assign is_audio = (r_kind == KIND_AUDIO);
    assign seq_pad  = SeqPadW'(r_count);

    always_comb begin
        n_hdr_pos    = r_hdr_pos;
        n_in_body    = r_in_body;
        n_remaining  = r_remaining;
        n_len_high   = r_len_high;
        n_kind       = r_kind;
        n_pt         = r_pt;
        n_codec      = r_codec;
        n_codec_seen = r_codec_seen;
        n_count      = r_count;
        n_halted     = r_halted;
        n_first      = r_first;
        o_res_valid  = 1'b0;
        o_res        = '0;
        if (i_valid && !r_halted) begin
            if (!r_in_body) begin
                if ((r_hdr_pos < POS_MAGIC_END) && (i_byte != MAGIC[r_hdr_pos[1:0]])) begin
                    n_halted          = 1'b1;
                    o_res_valid       = 1'b1;
                    o_res.magic_error = 1'b1;
                end else begin
                    if (r_hdr_pos == POS_PT) begin
                        n_pt = i_byte[PT_W-1:0];
                    end
                    if (r_hdr_pos == POS_KIND) begin
                        n_kind = i_byte[BYTE_W-1:BYTE_W-KIND_W];
                    end
                    if (r_hdr_pos == loff) begin
                        n_len_high = i_byte;
                    end
                    if (r_hdr_pos == loff + POS_W'(1)) begin
                        n_remaining = hdr_len;
                        n_hdr_pos   = '0;
                        if (is_audio && !r_codec_seen) begin
                            n_codec      = r_pt;
                            n_codec_seen = 1'b1;
                        end
                        if (hdr_len == '0) begin
                            if (is_video) begin
                                n_count = r_count + SEQ_BITS'(1);
                            end
                        end else begin
                            n_in_body = 1'b1;
                            n_first   = 1'b1;
                        end
                    end else begin
                        n_hdr_pos = r_hdr_pos + POS_W'(1);
                    end
                end
            end else begin
                n_first     = 1'b0;
                n_remaining = r_remaining - LEN_W'(1);
                if (r_remaining == LEN_W'(1)) begin
                    n_in_body = 1'b0;
                    if (is_video) begin
                        n_count = r_count + SEQ_BITS'(1);
                    end
                end
                if (is_video || is_audio) begin
                    o_res_valid           = 1'b1;
                    o_res.payload_byte    = i_byte;
                    o_res.channel         = is_audio ? CH_AUDIO : CH_VIDEO;
                    o_res.first_of_packet = r_first;
                    o_res.last_of_packet  = (r_remaining == LEN_W'(1));
                    o_res.payload_kind    = r_pt;
                    o_res.codec_pt        = r_codec;
                    o_res.packet_seq      = seq_pad[SEQ_OUT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos    <= '0;
            r_in_body    <= 1'b0;
            r_remaining  <= '0;
            r_len_high   <= '0;
            r_kind       <= '0;
            r_pt         <= '0;
            r_codec      <= '0;
            r_codec_seen <= 1'b0;
            r_count      <= '0;
            r_halted     <= 1'b0;
            r_first      <= 1'b0;
        end else begin
            r_hdr_pos    <= n_hdr_pos;
            r_in_body    <= n_in_body;
            r_remaining  <= n_remaining;
            r_len_high   <= n_len_high;
            r_kind       <= n_kind;
            r_pt         <= n_pt;
            r_codec      <= n_codec;
            r_codec_seen <= n_codec_seen;
            r_count      <= n_count;
            r_halted     <= n_halted;
            r_first      <= n_first;
        end
    end

    `AVPD_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_halted, r_halted)
    `AVPD_ASSERT_SAME(a_body_nonzero, i_clk, i_rst_n, r_in_body, r_remaining != '0)
    `AVPD_ASSERT_SAME(a_hdr_pos_range, i_clk, i_rst_n, !r_in_body, r_hdr_pos <= LOFF_DEFAULT + POS_W'(1))
    `AVPD_ASSERT_NEXT(a_err_halts, i_clk, i_rst_n, o_res_valid && o_res.magic_error, r_halted)
    `AVPD_ASSERT_SAME(a_first_in_body, i_clk, i_rst_n, r_first, r_in_body)

endmodule

>>> tb/av_packet_deframer_test.sv
// self-checking testbench for the av_packet_deframer byte-stream parser
module av_packet_deframer_test
    import avpd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] data;
        bit         hold;
    } t_feed_byte;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [BYTE_W-1:0]    s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 m_axis_tlast;

    t_feed_byte  byte_feed[$];
    t_result     pending_results[$];
    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt = 0;
    int unsigned results_checked = 0;
    int unsigned video_pkts = 0;
    int unsigned audio_pkts = 0;
    int unsigned silent_pkts = 0;
    int unsigned error_pos = 0;
    bit          in_taken = 1'b0;

    // parser shadow state
    logic [4:0]  hdr_pos = '0;
    logic        body_active = 1'b0;
    logic [15:0] body_left = '0;
    logic [7:0]  len_hi = '0;
    logic [3:0]  cur_kind = '0;
    logic [6:0]  cur_pt = '0;
    logic [6:0]  codec_id = '0;
    logic        codec_valid = 1'b0;
    logic [31:0] video_seq = '0;
    logic        stopped = 1'b0;
    logic        first_due = 1'b0;

    av_packet_deframer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic log_mismatch(input string msg);
        if (mismatch_cnt < 50)
            $display("MISMATCH at %0t ns: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    function automatic logic [4:0] length_pos(input logic [3:0] kind);
        if (kind == KIND_SHORT) return LOFF_SHORT;
        if (kind == KIND_AUDIO) return LOFF_AUDIO;
        return LOFF_DEFAULT;
    endfunction

    task automatic track_byte(input logic [7:0] b);
        t_result    r;
        logic [4:0] loff;
        logic       is_last;
        logic       is_first;
        logic       is_video;
        logic       is_audio;
        logic [31:0] seq;
        r = '0;
        if (stopped)
            return;
        if (!body_active) begin
            if (hdr_pos < MAGIC_LEN && b != MAGIC[hdr_pos]) begin
                stopped = 1'b1;
                r.magic_error = 1'b1;
                pending_results.push_back(r);
                return;
            end
            if (hdr_pos == POS_PT)
                cur_pt = b[6:0];
            if (hdr_pos == POS_KIND)
                cur_kind = b[7:4];
            loff = length_pos(cur_kind);
            if (hdr_pos == loff)
                len_hi = b;
            if (hdr_pos == loff + 1) begin
                body_left = {len_hi, b};
                hdr_pos = '0;
                if (cur_kind == KIND_AUDIO && !codec_valid) begin
                    codec_id = cur_pt;
                    codec_valid = 1'b1;
                end
                if (body_left == 0) begin
                    if (cur_kind <= KIND_VIDEO_MAX)
                        video_seq++;
                end else begin
                    body_active = 1'b1;
                    first_due = 1'b1;
                end
            end else begin
                hdr_pos++;
            end
            return;
        end
        is_last = (body_left == 1);
        is_first = first_due;
        is_video = (cur_kind <= KIND_VIDEO_MAX);
        is_audio = (cur_kind == KIND_AUDIO);
        seq = video_seq;
        first_due = 1'b0;
        body_left--;
        if (is_last) begin
            body_active = 1'b0;
            if (is_video)
                video_seq++;
        end
        if (!is_video && !is_audio)
            return;
        r.payload_byte = b;
        r.channel = is_audio ? CH_AUDIO : CH_VIDEO;
        r.first_of_packet = is_first;
        r.last_of_packet = is_last;
        r.payload_kind = cur_pt;
        r.codec_pt = codec_id;
        r.packet_seq = seq;
        pending_results.push_back(r);
    endtask

    task automatic queue_packet(input logic [3:0] kind, input logic [7:0] pt_byte,
                                input logic [15:0] body_len, input bit extreme_body,
                                input bit hold_first);
        logic [4:0] loff;
        int         hdr_len;
        t_feed_byte fb;
        loff = length_pos(kind);
        hdr_len = loff + 2;
        for (int i = 0; i < hdr_len; i++) begin
            if (i < MAGIC_LEN)
                fb.data = MAGIC[i];
            else if (i == POS_PT)
                fb.data = pt_byte;
            else if (i == POS_KIND)
                fb.data = {kind, 4'($urandom)};
            else if (i == loff)
                fb.data = body_len[15:8];
            else if (i == loff + 1)
                fb.data = body_len[7:0];
            else
                fb.data = 8'($urandom);
            fb.hold = (i == 0) && hold_first;
            byte_feed.push_back(fb);
        end
        for (int j = 0; j < body_len; j++) begin
            if (extreme_body)
                fb.data = j[0] ? 8'hff : 8'h00;
            else
                fb.data = 8'($urandom);
            fb.hold = 1'b0;
            byte_feed.push_back(fb);
        end
        if (kind <= KIND_VIDEO_MAX)
            video_pkts++;
        else if (kind == KIND_AUDIO)
            audio_pkts++;
        else
            silent_pkts++;
    endtask

    // input side and result-side ready, driven on the falling edge
    always @(negedge i_clk) begin : drive_inputs
        logic       nxt_valid;
        logic [7:0] nxt_data;
        bit         quiet;
        t_feed_byte nxt_fb;
        quiet = (cycle_cnt >= 400 && cycle_cnt < 1200);
        nxt_valid = s_axis_tvalid;
        nxt_data = s_axis_tdata;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!(s_axis_tvalid && !in_taken)) begin
            nxt_valid = 1'b0;
            if (byte_feed.size() != 0 && (quiet || $urandom_range(99) >= 20)
                    && !(byte_feed[0].hold && pending_results.size() != 0)) begin
                nxt_fb = byte_feed.pop_front();
                nxt_valid = 1'b1;
                nxt_data = nxt_fb.data;
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata <= nxt_data;
        m_axis_tready <= i_rst_n && (quiet || $urandom_range(99) >= 20);
    end

    // transfer monitor, sampled on the rising edge
    always @(posedge i_clk) begin : watch_ports
        t_result got;
        t_result want;
        cycle_cnt++;
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken)
            track_byte(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.payload_byte = m_axis_tdata[7:0];
            got.first_of_packet = m_axis_tdata[8];
            got.codec_pt = m_axis_tdata[15:9];
            got.packet_seq = m_axis_tdata[47:16];
            got.magic_error = m_axis_tdata[48];
            got.channel = m_axis_tuser[0];
            got.payload_kind = m_axis_tuser[7:1];
            got.last_of_packet = m_axis_tlast;
            if (pending_results.size() == 0) begin
                log_mismatch($sformatf("unexpected result, byte %h", got.payload_byte));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.payload_byte !== want.payload_byte)
                    log_mismatch($sformatf("payload_byte got %h want %h",
                                           got.payload_byte, want.payload_byte));
                if (got.channel !== want.channel)
                    log_mismatch($sformatf("channel got %b want %b",
                                           got.channel, want.channel));
                if (got.first_of_packet !== want.first_of_packet)
                    log_mismatch($sformatf("first_of_packet got %b want %b",
                                           got.first_of_packet, want.first_of_packet));
                if (got.last_of_packet !== want.last_of_packet)
                    log_mismatch($sformatf("last_of_packet got %b want %b",
                                           got.last_of_packet, want.last_of_packet));
                if (got.payload_kind !== want.payload_kind)
                    log_mismatch($sformatf("payload_kind got %h want %h",
                                           got.payload_kind, want.payload_kind));
                if (got.codec_pt !== want.codec_pt)
                    log_mismatch($sformatf("codec_pt got %h want %h",
                                           got.codec_pt, want.codec_pt));
                if (got.packet_seq !== want.packet_seq)
                    log_mismatch($sformatf("packet_seq got %h want %h",
                                           got.packet_seq, want.packet_seq));
                if (got.magic_error !== want.magic_error)
                    log_mismatch($sformatf("magic_error got %b want %b",
                                           got.magic_error, want.magic_error));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin : run_stimulus
        int unsigned r;
        logic [15:0] len;
        logic [3:0]  kind;
        t_feed_byte  fb;
        int unsigned rand_start;

        // directed packets
        queue_packet(4'h0, 8'h80, 16'd1, 1'b0, 1'b0);
        queue_packet(4'h3, 8'h7f, 16'd2, 1'b1, 1'b0);
        queue_packet(4'h2, 8'h05, 16'd0, 1'b0, 1'b0);
        queue_packet(4'h3, 8'h11, 16'd0, 1'b0, 1'b0);
        queue_packet(4'h4, 8'hff, 16'd1, 1'b0, 1'b0);
        queue_packet(4'hf, 8'h2a, 16'd3, 1'b0, 1'b0);
        queue_packet(4'h1, 8'h00, 16'd3, 1'b1, 1'b1);
        queue_packet(4'h3, 8'h45, 16'd1, 1'b0, 1'b0);

        // random well-formed packets
        rand_start = byte_feed.size();
        while (byte_feed.size() - rand_start < 900) begin
            r = $urandom_range(99);
            if (r < 40)
                kind = 4'($urandom_range(2));
            else if (r < 70)
                kind = KIND_AUDIO;
            else
                kind = 4'($urandom_range(15, 4));
            r = $urandom_range(99);
            if (r < 8)
                len = 16'd0;
            else if (r < 80)
                len = 16'($urandom_range(24, 1));
            else if (r < 96)
                len = 16'($urandom_range(80, 25));
            else
                len = 16'($urandom_range(400, 256));
            queue_packet(kind, 8'($urandom), len, 1'b0, $urandom_range(39) == 0);
        end

        // closing broken packet: the magic fails at a random byte, then the stream is dead
        error_pos = $urandom_range(MAGIC_LEN - 1);
        for (int i = 0; i < error_pos; i++) begin
            fb.data = MAGIC[i];
            fb.hold = 1'b0;
            byte_feed.push_back(fb);
        end
        do
            fb.data = 8'($urandom);
        while (fb.data == MAGIC[error_pos]);
        byte_feed.push_back(fb);
        for (int i = 0; i < 12; i++) begin
            fb.data = (i < MAGIC_LEN) ? MAGIC[i] : 8'($urandom);
            byte_feed.push_back(fb);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (byte_feed.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (pending_results.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("covered %0d video, %0d audio and %0d other packets, %0d results compared",
                 video_pkts, audio_pkts, silent_pkts, results_checked);
        $display("stream ended with a magic mismatch on header byte %0d", error_pos);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
